/* hdl/cpos_pkg.sv */
// Shared types and constants for the closest-point-on-segment pipeline.
package cpos_pkg;

  localparam int COORD_BITS  = 24;
  localparam int FRAC_T_BITS = 16;
  localparam int CFG_BITS    = 16;
  localparam int DIFF_W      = COORD_BITS + 1;
  localparam int PROD_W      = 2 * DIFF_W;
  localparam int LEN_W       = PROD_W;
  localparam int DOT_W       = PROD_W + 1;
  localparam int STEP_W      = DIFF_W + FRAC_T_BITS + 1;
  localparam int Q_W         = STEP_W - FRAC_T_BITS;
  localparam int SUM_W       = Q_W + 1;
  localparam logic [CFG_BITS-1:0] MIN_LEN_SQ_RST = CFG_BITS'(7);

  typedef enum logic [1:0] {
    CASE_PROJ  = 2'd0,
    CASE_NOSEG = 2'd1,
    CASE_DEGEN = 2'd2
  } case_code_t;

  typedef enum logic [1:0] {
    TSEL_ZERO = 2'd0,
    TSEL_FULL = 2'd1,
    TSEL_DIV  = 2'd2
  } tsel_t;

  typedef struct packed {
    logic                         has_segment;
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
    logic signed [COORD_BITS-1:0] seg_a_x;
    logic signed [COORD_BITS-1:0] seg_a_y;
    logic signed [COORD_BITS-1:0] seg_b_x;
    logic signed [COORD_BITS-1:0] seg_b_y;
  } in_beat_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] near_x;
    logic signed [COORD_BITS-1:0] near_y;
    case_code_t                   case_code;
  } out_beat_t;

  typedef struct packed {
    logic                         vld;
    logic signed [COORD_BITS-1:0] base_x;
    logic signed [COORD_BITS-1:0] base_y;
    logic signed [DIFF_W-1:0]     dx;
    logic signed [DIFF_W-1:0]     dy;
    logic [LEN_W-1:0]             len;
    logic [LEN_W-1:0]             rem;
    logic [FRAC_T_BITS-1:0]       quo;
    tsel_t                        tsel;
    case_code_t                   code;
  } div_t;

endpackage

/* hdl/closest_point_on_segment_top.sv */
// Top level of the closest-point-on-segment pipeline.
// Takes one query per cycle while not stalled and returns one result per query, in order.
// The pipeline has 4 front stages (differences, 25x25 products, sums, classification), 16
// division stages that each settle one bit of the fraction t with one 51-bit compare and
// subtract, then 2 stages for the offset multiply and the saturating add. When out_ready
// is low with a result waiting, the whole pipeline holds and in_ready drops in the same cycle.
// min_len_sq resets to 7 and is sampled at the classification stage.
module closest_point_on_segment_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  cpos_pkg::in_beat_t            in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output cpos_pkg::out_beat_t           out_data,
  input  logic                          cfg_we,
  input  logic [cpos_pkg::CFG_BITS-1:0] cfg_data
);
  import cpos_pkg::*;

  logic                adv;
  logic [CFG_BITS-1:0] min_len_sq;
  div_t                chain [FRAC_T_BITS+1];

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_len_sq <= MIN_LEN_SQ_RST;
    end else if (cfg_we) begin
      min_len_sq <= cfg_data;
    end
  end

  cpos_front u_front (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .in_valid   (in_valid),
    .in_data    (in_data),
    .min_len_sq (min_len_sq),
    .out_stage  (chain[0])
  );

  for (genvar i = 0; i < FRAC_T_BITS; i++) begin : g_div
    cpos_div_step u_step (
      .clk       (clk),
      .rst       (rst),
      .adv       (adv),
      .in_stage  (chain[i]),
      .out_stage (chain[i+1])
    );
  end

  cpos_lerp u_lerp (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_stage  (chain[FRAC_T_BITS]),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

`ifndef SYNTH
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");
  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without a blocked result");
  a_special_t_zero: assert property (@(posedge clk) disable iff (rst)
    chain[FRAC_T_BITS].vld && chain[FRAC_T_BITS].code != CASE_PROJ
    |-> chain[FRAC_T_BITS].tsel == TSEL_ZERO)
    else $error("special case reached offset stage with nonzero t");
`endif

endmodule

/* hdl/cpos_front.sv */
// Front stages: differences, products, sums and case classification.
module cpos_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           adv,
  input  logic                           in_valid,
  input  cpos_pkg::in_beat_t             in_data,
  input  logic [cpos_pkg::CFG_BITS-1:0]  min_len_sq,
  output cpos_pkg::div_t                 out_stage
);
  import cpos_pkg::*;

  logic                         v1, v2, v3;
  logic                         has1, has2, has3;
  logic signed [COORD_BITS-1:0] px1, py1, ax1, ay1;
  logic signed [COORD_BITS-1:0] px2, py2, ax2, ay2;
  logic signed [COORD_BITS-1:0] px3, py3, ax3, ay3;
  logic signed [DIFF_W-1:0]     dx1, dy1, qx1, qy1;
  logic signed [DIFF_W-1:0]     dx2, dy2, dx3, dy3;
  logic signed [PROD_W-1:0]     sqx, sqy, pdx, pdy;
  logic [LEN_W-1:0]             len3;
  logic signed [DOT_W-1:0]      dot3;
  logic                         degen, zero, full;
  div_t                         out_stage_next;

  always_comb begin
    degen = (len3 < LEN_W'(min_len_sq)) || (len3 == '0);
    zero  = dot3[DOT_W-1] || (dot3 == '0);
    full  = !zero && (dot3[LEN_W-1:0] >= len3);
    out_stage_next.vld    = v3;
    out_stage_next.dx     = dx3;
    out_stage_next.dy     = dy3;
    out_stage_next.len    = len3;
    out_stage_next.rem    = dot3[LEN_W-1:0];
    out_stage_next.quo    = '0;
    out_stage_next.base_x = ax3;
    out_stage_next.base_y = ay3;
    out_stage_next.tsel   = TSEL_ZERO;
    out_stage_next.code   = CASE_PROJ;
    if (!has3) begin
      out_stage_next.base_x = px3;
      out_stage_next.base_y = py3;
      out_stage_next.code   = CASE_NOSEG;
    end else if (degen) begin
      out_stage_next.code = CASE_DEGEN;
    end else if (zero) begin
      out_stage_next.tsel = TSEL_ZERO;
    end else if (full) begin
      out_stage_next.tsel = TSEL_FULL;
    end else begin
      out_stage_next.tsel = TSEL_DIV;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1            <= 1'b0;
      v2            <= 1'b0;
      v3            <= 1'b0;
      out_stage.vld <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
      has1 <= in_data.has_segment;
      px1 <= in_data.point_x;
      py1 <= in_data.point_y;
      ax1 <= in_data.seg_a_x;
      ay1 <= in_data.seg_a_y;
      dx1 <= DIFF_W'(in_data.seg_b_x) - DIFF_W'(in_data.seg_a_x);
      dy1 <= DIFF_W'(in_data.seg_b_y) - DIFF_W'(in_data.seg_a_y);
      qx1 <= DIFF_W'(in_data.point_x) - DIFF_W'(in_data.seg_a_x);
      qy1 <= DIFF_W'(in_data.point_y) - DIFF_W'(in_data.seg_a_y);

      v2 <= v1;
      has2 <= has1;
      px2 <= px1;
      py2 <= py1;
      ax2 <= ax1;
      ay2 <= ay1;
      dx2 <= dx1;
      dy2 <= dy1;
      sqx <= dx1 * dx1;
      sqy <= dy1 * dy1;
      pdx <= qx1 * dx1;
      pdy <= qy1 * dy1;

      v3 <= v2;
      has3 <= has2;
      px3 <= px2;
      py3 <= py2;
      ax3 <= ax2;
      ay3 <= ay2;
      dx3 <= dx2;
      dy3 <= dy2;
      len3 <= $unsigned(sqx) + $unsigned(sqy);
      dot3 <= DOT_W'(pdx) + DOT_W'(pdy);

      out_stage <= out_stage_next;
    end
  end

endmodule

/* hdl/cpos_div_step.sv */
// One restoring-division step for the projection fraction.
module cpos_div_step (
  input  logic           clk,
  input  logic           rst,
  input  logic           adv,
  input  cpos_pkg::div_t in_stage,
  output cpos_pkg::div_t out_stage
);
  import cpos_pkg::*;

  logic [LEN_W:0] rem2;
  logic           ge;
  div_t           out_stage_next;

  always_comb begin
    rem2 = {in_stage.rem, 1'b0};
    ge   = rem2 >= {1'b0, in_stage.len};
    out_stage_next     = in_stage;
    out_stage_next.rem = ge ? LEN_W'(rem2 - {1'b0, in_stage.len}) : rem2[LEN_W-1:0];
    out_stage_next.quo = {in_stage.quo[FRAC_T_BITS-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_stage.vld <= 1'b0;
    end else if (adv) begin
      out_stage <= out_stage_next;
    end
  end

endmodule

/* hdl/cpos_lerp.sv */
// Back stages: offset multiply, add with saturation, output register.
module cpos_lerp (
  input  logic                clk,
  input  logic                rst,
  input  logic                adv,
  input  cpos_pkg::div_t      in_stage,
  output logic                out_valid,
  output cpos_pkg::out_beat_t out_data
);
  import cpos_pkg::*;

  logic [FRAC_T_BITS:0]         t;
  logic                         v1;
  logic signed [COORD_BITS-1:0] bx1, by1;
  logic signed [STEP_W-1:0]     stx, sty;
  case_code_t                   code1;
  logic signed [SUM_W-1:0]      sumx, sumy;

  function automatic logic signed [COORD_BITS-1:0] sat(input logic signed [SUM_W-1:0] v);
    logic hi_same;
    hi_same = (v[SUM_W-1:COORD_BITS-1] == '0) || (v[SUM_W-1:COORD_BITS-1] == '1);
    if (hi_same) begin
      sat = v[COORD_BITS-1:0];
    end else if (v[SUM_W-1]) begin
      sat = {1'b1, {(COORD_BITS-1){1'b0}}};
    end else begin
      sat = {1'b0, {(COORD_BITS-1){1'b1}}};
    end
  endfunction

  always_comb begin
    case (in_stage.tsel)
      TSEL_FULL: t = {1'b1, {FRAC_T_BITS{1'b0}}};
      TSEL_DIV:  t = {1'b0, in_stage.quo};
      default:   t = '0;
    endcase
    sumx = SUM_W'(bx1) + SUM_W'(stx >>> FRAC_T_BITS);
    sumy = SUM_W'(by1) + SUM_W'(sty >>> FRAC_T_BITS);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v1    <= in_stage.vld;
      bx1   <= in_stage.base_x;
      by1   <= in_stage.base_y;
      code1 <= in_stage.code;
      stx   <= in_stage.dx * $signed({1'b0, t});
      sty   <= in_stage.dy * $signed({1'b0, t});

      out_valid          <= v1;
      out_data.near_x    <= sat(sumx);
      out_data.near_y    <= sat(sumy);
      out_data.case_code <= code1;
    end
  end

endmodule

/* test/tb_closest_point_on_segment_top.sv */
// Self-checking testbench for the closest-point-on-segment pipeline.
module tb_closest_point_on_segment_top;
  timeunit 1ns;
  timeprecision 1ps;
  import cpos_pkg::*;

  localparam longint CLAMP_HI = (longint'(1) <<< (COORD_BITS - 1)) - 1;
  localparam longint CLAMP_LO = -(longint'(1) <<< (COORD_BITS - 1));
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 40;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_beat_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_beat_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_BITS-1:0] cfg_data = '0;

  closest_point_on_segment_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  in_beat_t query_q[$];
  out_beat_t nearest_q[$];
  logic [CFG_BITS-1:0] min_len_sq = MIN_LEN_SQ_RST;
  logic calm = 1'b0;
  logic in_took = 1'b0;
  logic out_took = 1'b0;
  int send_gap = 0;
  int recv_hold = 0;
  int mismatches = 0;
  int idle_cycles = 0;

  function automatic logic signed [COORD_BITS-1:0] saturate(longint v);
    if (v > CLAMP_HI) v = CLAMP_HI;
    if (v < CLAMP_LO) v = CLAMP_LO;
    return v[COORD_BITS-1:0];
  endfunction

  function automatic out_beat_t nearest_point(in_beat_t q, logic [CFG_BITS-1:0] floor_sq);
    longint dx, dy, qx, qy, len, dot, t;
    logic [127:0] num;
    out_beat_t r;
    if (!q.has_segment) begin
      r.near_x = q.point_x;
      r.near_y = q.point_y;
      r.case_code = CASE_NOSEG;
      return r;
    end
    dx = longint'(q.seg_b_x) - longint'(q.seg_a_x);
    dy = longint'(q.seg_b_y) - longint'(q.seg_a_y);
    len = dx * dx + dy * dy;
    if (len == 0 || len < longint'(floor_sq)) begin
      r.near_x = q.seg_a_x;
      r.near_y = q.seg_a_y;
      r.case_code = CASE_DEGEN;
      return r;
    end
    qx = longint'(q.point_x) - longint'(q.seg_a_x);
    qy = longint'(q.point_y) - longint'(q.seg_a_y);
    dot = qx * dx + qy * dy;
    if (dot <= 0) t = 0;
    else if (dot >= len) t = longint'(1) <<< FRAC_T_BITS;
    else begin
      num = 128'(dot) << FRAC_T_BITS;
      t = longint'(num / 128'(len));
    end
    r.near_x = saturate(longint'(q.seg_a_x) + ((dx * t) >>> FRAC_T_BITS));
    r.near_y = saturate(longint'(q.seg_a_y) + ((dy * t) >>> FRAC_T_BITS));
    r.case_code = CASE_PROJ;
    return r;
  endfunction

  function automatic logic signed [COORD_BITS-1:0] rand_coord();
    return COORD_BITS'($urandom);
  endfunction

  function automatic logic signed [COORD_BITS-1:0] near_coord(logic signed [COORD_BITS-1:0] c,
                                                          int span);
    return saturate(longint'(c) + $urandom_range(0, 2 * span) - span);
  endfunction

  function automatic in_beat_t random_query();
    in_beat_t q;
    int kind;
    kind = $urandom_range(0, 9);
    q.has_segment = 1'b1;
    q.point_x = rand_coord();
    q.point_y = rand_coord();
    q.seg_a_x = rand_coord();
    q.seg_a_y = rand_coord();
    q.seg_b_x = rand_coord();
    q.seg_b_y = rand_coord();
    case (kind)
      0: q.has_segment = 1'b0;
      1: begin
        q.seg_b_x = near_coord(q.seg_a_x, 200);
        q.seg_b_y = near_coord(q.seg_a_y, 200);
      end
      2: begin
        q.seg_b_x = q.seg_a_x;
        q.seg_b_y = q.seg_a_y;
      end
      3, 4: begin
        q.seg_a_x = near_coord(0, 40000);
        q.seg_a_y = near_coord(0, 40000);
        q.seg_b_x = near_coord(0, 40000);
        q.seg_b_y = near_coord(0, 40000);
        q.point_x = near_coord(0, 60000);
        q.point_y = near_coord(0, 60000);
      end
      5: begin
        q.point_x = near_coord(q.seg_a_x, 3000);
        q.point_y = near_coord(q.seg_a_y, 3000);
      end
      6: begin
        q.point_x = near_coord(q.seg_b_x, 3000);
        q.point_y = near_coord(q.seg_b_y, 3000);
      end
      default: ;
    endcase
    return q;
  endfunction

  function automatic in_beat_t make_query(logic has, longint px, longint py, longint ax,
                                          longint ay, longint bx, longint by);
    in_beat_t q;
    q.has_segment = has;
    q.point_x = px[COORD_BITS-1:0];
    q.point_y = py[COORD_BITS-1:0];
    q.seg_a_x = ax[COORD_BITS-1:0];
    q.seg_a_y = ay[COORD_BITS-1:0];
    q.seg_b_x = bx[COORD_BITS-1:0];
    q.seg_b_y = by[COORD_BITS-1:0];
    return q;
  endfunction

  task automatic settle();
    while (query_q.size() != 0 || in_valid || nearest_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_min_len(logic [CFG_BITS-1:0] v);
    settle();
    cfg_we <= 1'b1;
    cfg_data <= v;
    min_len_sq = v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  always @(posedge clk) begin
    in_took <= in_valid && in_ready;
    out_took <= out_valid && out_ready;
    if (!rst && in_valid && in_ready) nearest_q.push_back(nearest_point(in_data, min_len_sq));
    if (!rst && out_valid && out_ready) begin
      if (nearest_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat %h", out_data);
      end else begin
        out_beat_t want;
        want = nearest_q.pop_front();
        if (want.near_x !== out_data.near_x || want.near_y !== out_data.near_y ||
            want.case_code !== out_data.case_code) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: want x=%0d y=%0d case=%0d got x=%0d y=%0d case=%0d",
                     want.near_x, want.near_y, want.case_code,
                     out_data.near_x, out_data.near_y, out_data.case_code);
        end
      end
    end
    if ((in_valid && in_ready) || (out_valid && out_ready) ||
        (query_q.size() == 0 && !in_valid && nearest_q.size() == 0)) idle_cycles <= 0;
    else if (!rst) idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_closest_point_on_segment_top: errors");
      $finish;
    end
  end

  always @(negedge clk) begin
    int gap, hold;
    gap = send_gap;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (in_took) gap = calm ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
        gap--;
        in_valid <= 1'b0;
      end else if (query_q.size() != 0) begin
        in_data <= query_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
    send_gap <= gap;
    hold = recv_hold;
    if (out_took) hold = calm ? 0 : $urandom_range(0, 11);
    if (hold > 0) begin
      hold--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= !rst;
    end
    recv_hold <= hold;
  end

  initial begin
    logic [CFG_BITS-1:0] settings[5];
    settings = '{16'd0, 16'd65535, 16'd7, 16'd1, 16'd0};
    settings[3] = $urandom_range(1, 65534);
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    query_q.push_back(make_query(0, CLAMP_HI, CLAMP_LO, 0, 0, 5, 5));
    query_q.push_back(make_query(0, CLAMP_LO, CLAMP_HI, -1, -1, -1, -1));
    query_q.push_back(make_query(1, 0, 0, 100, -100, 100, -100));
    query_q.push_back(make_query(1, 0, 0, 100, 100, 101, 102));
    query_q.push_back(make_query(1, 0, 0, 100, 100, 102, 102));
    query_q.push_back(make_query(1, 0, 0, CLAMP_LO, CLAMP_LO, CLAMP_HI, CLAMP_HI));
    query_q.push_back(make_query(1, CLAMP_HI, CLAMP_LO, CLAMP_LO, CLAMP_LO, CLAMP_HI, CLAMP_HI));
    query_q.push_back(make_query(1, CLAMP_LO, CLAMP_LO, CLAMP_HI, CLAMP_HI, CLAMP_LO, CLAMP_LO));
    query_q.push_back(make_query(1, CLAMP_HI, CLAMP_HI, CLAMP_LO, CLAMP_HI, CLAMP_HI, CLAMP_LO));
    query_q.push_back(make_query(1, -5000, 0, 0, 0, 1000, 0));
    query_q.push_back(make_query(1, 9000, 7, 0, 0, 1000, 0));
    query_q.push_back(make_query(1, 333, 999, 0, 0, 1000, 0));
    query_q.push_back(make_query(1, 500, 500, 0, 0, 1000, 1000));
    query_q.push_back(make_query(1, -7, 3, 0, 0, -3, -1000));
    query_q.push_back(make_query(1, 0, 0, CLAMP_HI, CLAMP_HI, CLAMP_HI, CLAMP_HI));
    query_q.push_back(make_query(1, 1, 1, CLAMP_LO, 0, CLAMP_HI, 1));
    query_q.push_back(make_query(1, 12, -40, 0, 0, 0, 0));
    query_q.push_back(make_query(1, 77, 77, -3, 8, 3, -8));
    for (int phase = 0; phase < 5; phase++) begin
      write_min_len(settings[phase]);
      if (phase == 0) query_q.push_back(make_query(1, 5, 5, 10, 10, 10, 10));
      calm = (phase == 2);
      for (int k = 0; k < 166; k++) query_q.push_back(random_query());
    end
    settle();
    if (mismatches == 0) $display("tb_closest_point_on_segment_top: clean");
    else $display("tb_closest_point_on_segment_top: errors");
    $finish;
  end
endmodule
